// File: rtl/core/htt_pkg.sv
// package: constants, codes and helpers of the homing trajectory block
`default_nettype none
package htt_pkg;
  localparam int FracBitsDef = 8;
  localparam int TicksPerSec = 50;
  localparam int HomeCurrent = 3000;
  localparam int HomeSpeed = -300;

  localparam logic [1:0] ST_EMERGENCY = 2'd0;
  localparam logic [1:0] ST_DRIVE = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HOMING = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [1:0] MODE_SPEED = 2'd1;
  localparam logic [1:0] MODE_POS = 2'd2;

  localparam logic [2:0] REG_MOTOR = 3'd0;
  localparam logic [2:0] REG_GOAL_A = 3'd1;
  localparam logic [2:0] REG_GOAL_B = 3'd2;
  localparam logic [2:0] REG_VLIM = 3'd3;
  localparam logic [2:0] REG_ACCEL = 3'd4;
  localparam logic [2:0] REG_DECEL = 3'd5;

  // radicand width: 2*decel (32b) * |err| (33b)
  localparam int RadW = 64;
  localparam int RootW = 32;
endpackage
`default_nettype wire

// File: rtl/core/homing_trapezoid_trajectory_top.sv
// homing and trapezoid trajectory: top level, sequencer and state
// feedback and no-result ticks end in idle; homing ticks give a result from S_HOME,
// near-goal ticks from S_VEL then S_POS; profile ticks run S_VEL, S_SQRT (serial
// square root, accel step divided alongside), S_DIV (divide by 50) and S_POS
// input is taken while a result waits; a new result holds until the register is free
// synchronous active-low reset restores register defaults and clears the tick state
`default_nettype none
module homing_trapezoid_trajectory_top import htt_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [1:0]         in_system_state,
  input  wire logic signed [15:0] in_motor_current,
  input  wire logic signed [31:0] in_motor_angle,
  input  wire logic               in_buttons_present,
  input  wire logic               in_button_a,
  input  wire logic               in_button_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_cmd_motor,
  output logic [1:0]              out_cmd_mode,
  output logic signed [31:0]      out_cmd_target,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_VEL, S_DIV, S_POS, S_HOME} state_t;

  localparam logic [36:0] Near = 37'd1 << FRAC_BITS;
  localparam logic signed [31:0] HomeTarget = 32'(HomeSpeed * (1 << FRAC_BITS));
  localparam logic [31:0] GoalBRst = 32'(30000 * (1 << FRAC_BITS));
  localparam logic [30:0] VlimRst = 31'(2000 * (1 << FRAC_BITS));
  localparam logic [30:0] AccRst = 31'(1000 * (1 << FRAC_BITS));

  state_t state_r;
  logic [3:0] motor_r;
  logic signed [31:0] goal_a_r, goal_b_r;
  logic [30:0] vlim_r, acc_r, dec_r;
  logic [1:0] last_st_r, phase_r;
  logic signed [15:0] cur_r;
  logic signed [31:0] ang_r, off_r, goal_r, pos_r;
  logic signed [31:0] vel_r;
  logic signed [32:0] err_r;
  logic [31:0] dq_r;     // quotient bits of the running divide by 50
  logic [32:0] drem_r;
  logic [5:0] dcnt_r;
  logic [31:0] dnum_r;
  logic out_valid_r;
  logic [3:0] out_motor_r;
  logic [1:0] out_mode_r;
  logic signed [31:0] out_target_r;

  logic accept, sq_done;
  logic [31:0] sq_root;
  logic [32:0] aerr;
  logic [31:0] avel;
  logic [RadW-1:0] radicand;
  logic out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_cmd_motor = out_motor_r;
  assign out_cmd_mode = out_mode_r;
  assign out_cmd_target = out_target_r;

  assign aerr = err_r[32] ? 33'(-err_r) : 33'(err_r);
  assign avel = vel_r[31] ? 32'(-vel_r) : 32'(vel_r);
  assign radicand = RadW'({dec_r, 1'b0}) * RadW'(aerr);

  logic sq_go_r;
  htt_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go_r), .radicand(radicand),
    .done(sq_done), .root(sq_root)
  );

  // tick goal selection
  logic signed [31:0] tick_goal;
  always_comb begin
    tick_goal = goal_r;
    if (in_buttons_present) begin
      if (in_button_a) tick_goal = goal_a_r;
      else if (in_button_b) tick_goal = goal_b_r;
    end
  end

  // accel step per tick, divided by 50 while the root runs
  logic [31:0] step;
  assign step = dq_r;

  logic signed [33:0] vt, v_up, v_dn;
  logic signed [31:0] vel_new;
  logic [31:0] safe;
  assign safe = (sq_root > 32'(vlim_r)) ? 32'(vlim_r) : sq_root;
  always_comb begin
    vt = err_r[32] ? -34'(safe) : 34'(safe);
    v_up = 34'(vel_r) + 34'(step);
    v_dn = 34'(vel_r) - 34'(step);
    vel_new = vel_r;
    if (34'(vel_r) < vt) vel_new = (v_up > vt) ? 32'(vt) : 32'(v_up);
    else if (34'(vel_r) > vt) vel_new = (v_dn < vt) ? 32'(vt) : 32'(v_dn);
  end

  logic signed [33:0] pos_sum;
  logic [33:0] dtrial;
  logic [32:0] drem_nxt;
  logic [31:0] dq_nxt;
  assign dtrial = {drem_r, dnum_r[31]};
  always_comb begin
    pos_sum = 34'(pos_r) + (vel_r[31] ? -34'(dq_r) : 34'(dq_r));
  end

  // restoring divide by 50, one quotient bit per cycle
  always_comb begin
    if (dtrial >= 34'(TicksPerSec)) begin
      drem_nxt = 33'(dtrial - 34'(TicksPerSec));
      dq_nxt = {dq_r[30:0], 1'b1};
    end else begin
      drem_nxt = 33'(dtrial);
      dq_nxt = {dq_r[30:0], 1'b0};
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      motor_r <= 4'd1; goal_a_r <= '0; goal_b_r <= GoalBRst;
      vlim_r <= VlimRst; acc_r <= AccRst; dec_r <= AccRst;
      last_st_r <= ST_EMERGENCY; phase_r <= PH_IDLE;
      cur_r <= '0; ang_r <= '0; off_r <= '0; goal_r <= '0;
      pos_r <= '0; vel_r <= '0;
      out_valid_r <= 1'b0; sq_go_r <= 1'b0;
    end else begin
      sq_go_r <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MOTOR:  motor_r <= cfg_data[3:0];
          REG_GOAL_A: goal_a_r <= cfg_data;
          REG_GOAL_B: goal_b_r <= cfg_data;
          REG_VLIM:   vlim_r <= cfg_data[30:0];
          REG_ACCEL:  acc_r <= cfg_data[30:0];
          REG_DECEL:  dec_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (accept) begin
          if (!in_command) begin
            cur_r <= in_motor_current;
            ang_r <= in_motor_angle;
            if (in_system_state == ST_EMERGENCY) phase_r <= PH_IDLE;
            else if (last_st_r != ST_DRIVE && in_system_state == ST_DRIVE)
              phase_r <= PH_HOMING;
            last_st_r <= in_system_state;
          end else if (last_st_r == ST_DRIVE) begin
            if (phase_r == PH_HOMING) begin
              if ((cur_r > 16'sd3000) || (cur_r < -16'sd3000)) begin
                off_r <= ang_r; goal_r <= goal_a_r; pos_r <= goal_a_r;
                vel_r <= '0; phase_r <= PH_DONE;
              end else begin
                state_r <= S_HOME;
              end
            end else if (phase_r == PH_DONE) begin
              goal_r <= tick_goal;
              err_r <= 33'(tick_goal) - 33'(pos_r);
              state_r <= S_VEL;
            end
          end
        end
        S_HOME: if (out_free) begin
          out_valid_r <= 1'b1; out_motor_r <= motor_r;
          out_mode_r <= MODE_SPEED; out_target_r <= HomeTarget;
          state_r <= S_IDLE;
        end
        S_VEL: begin
          // near test, else launch root
          if ((37'(aerr) * 37'd10 < Near) &&
              (38'(avel) * 38'(TicksPerSec) < 38'(acc_r))) begin
            pos_r <= goal_r; vel_r <= '0;
            dq_r <= '0; state_r <= S_POS;
          end else begin
            sq_go_r <= 1'b1;
            dnum_r <= 32'(acc_r) + 32'd25;
            drem_r <= '0; dq_r <= '0; dcnt_r <= 6'd32;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            vel_r <= vel_new;
            dnum_r <= (vel_new[31] ? 32'(-vel_new) : 32'(vel_new)) + 32'd25;
            drem_r <= '0; dq_r <= '0; dcnt_r <= 6'd32;
            state_r <= S_DIV;
          end else if (dcnt_r != 6'd0) begin
            dnum_r <= {dnum_r[30:0], 1'b0};
            drem_r <= drem_nxt;
            dq_r <= dq_nxt;
            dcnt_r <= dcnt_r - 6'd1;
          end
        end
        S_DIV: begin
          dnum_r <= {dnum_r[30:0], 1'b0};
          drem_r <= drem_nxt;
          dq_r <= dq_nxt;
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) state_r <= S_POS;
        end
        S_POS: if (out_free) begin
          pos_r <= sat(pos_sum);
          state_r <= S_IDLE;
          out_valid_r <= 1'b1; out_motor_r <= motor_r; out_mode_r <= MODE_POS;
          out_target_r <= sat(34'(sat(pos_sum)) + 34'(off_r));
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/htt_isqrt.sv
// bit-serial integer square root, two radicand bits per cycle
`default_nettype none
module htt_isqrt import htt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RadW-1:0]   radicand,
  output logic                   done,
  output logic [RootW-1:0]       root
);
  logic [RadW-1:0]  x_r, x_nxt;
  logic [RootW+1:0] rem_r, rem_nxt;
  logic [RootW-1:0] q_r, q_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] shifted;

  always_comb begin
    shifted = {rem_r[RootW-1:0], x_r[RadW-1 -: 2]};
    trial = {q_r, 2'b01};
    x_nxt = x_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt = radicand;
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = 6'(RootW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[RadW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        q_nxt = {q_r[RootW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign root = q_nxt;
endmodule
`default_nettype wire
